// ===== src/omgr_pkg.sv =====
// Shared constants, types and index helpers for the octree multigrid restriction block.
`default_nettype none

package omgr_pkg;

    localparam int CELLS_PER_SIDE = 8;
    localparam int STORE_DEPTH    = CELLS_PER_SIDE * CELLS_PER_SIDE * CELLS_PER_SIDE;
    localparam int IDX_W          = $clog2(STORE_DEPTH);
    localparam int COORD_W        = 3;
    localparam int OCT_W          = 3;
    localparam int VALUE_W        = 32;
    localparam int S_TDATA_W      = 48;
    localparam int M_TDATA_W      = 32;

    // s_tuser command codes
    localparam logic CMD_ACCUM = 1'b0;
    localparam logic CMD_READ  = 1'b1;

    typedef logic [IDX_W-1:0]          idx_t;
    typedef logic [COORD_W-1:0]        coord_t;
    typedef logic [OCT_W-1:0]          oct_t;
    typedef logic signed [VALUE_W-1:0] value_t;

    function automatic logic in_patch(input coord_t x, input coord_t y, input coord_t z);
        return (int'(x) < CELLS_PER_SIDE) && (int'(y) < CELLS_PER_SIDE)
            && (int'(z) < CELLS_PER_SIDE);
    endfunction

    function automatic idx_t cell_index(input int x, input int y, input int z);
        int lin;
        lin = x + y * CELLS_PER_SIDE + z * CELLS_PER_SIDE * CELLS_PER_SIDE;
        return idx_t'(lin);
    endfunction

    // Fine cell of a child octant to its coarse cell in the parent patch.
    function automatic idx_t coarse_index(input oct_t oct, input coord_t x, input coord_t y,
                                          input coord_t z);
        int cx;
        int cy;
        int cz;
        cx = (int'(x) + (oct[0] ? CELLS_PER_SIDE : 0)) >> 1;
        cy = (int'(y) + (oct[1] ? CELLS_PER_SIDE : 0)) >> 1;
        cz = (int'(z) + (oct[2] ? CELLS_PER_SIDE : 0)) >> 1;
        return cell_index(cx, cy, cz);
    endfunction

endpackage

`default_nettype wire

// ===== src/octree_multigrid_restriction_top.sv =====
// Top level: coarse-patch store with read-modify-write accumulate and read-and-clear.
`default_nettype none

// Restricts eight fine child patches into one coarse patch held in a CELLS_PER_SIDE^3 x 32
// memory. Accumulate transactions (s_tuser = 0) add fine_value >>> 3 into the coarse cell,
// saturating; read transactions (s_tuser = 1) return the coarse cell on m_tdata and clear it.
// One transaction is accepted per cycle while s_tready is high: the item is registered
// together with the memory read, the sum is formed and written back in the next cycle,
// and a write to the same cell by the item just ahead is forwarded. Outside the clearing
// pass, s_tready drops only while a read waits on an output register that holds an
// untaken result; every transaction behind it waits too. After reset a clearing pass
// zeroes all STORE_DEPTH (512) cells, one per cycle; s_tready stays low until it ends.
module octree_multigrid_restriction_top (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    // s_tdata: fine_value[31:0], octant[34:32], cell_x[37:35], cell_y[40:38],
    //          cell_z[43:41], zero[47:44]
    input  wire logic [omgr_pkg::S_TDATA_W-1:0]  s_tdata,
    // s_tuser: cmd[0]
    input  wire logic                            s_tuser,
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    // m_tdata: coarse_value[31:0]
    output logic [omgr_pkg::M_TDATA_W-1:0]       m_tdata
);
    import omgr_pkg::*;

    value_t mem [STORE_DEPTH];

    logic   clearing_reg;
    idx_t   clear_cnt_reg;

    logic   st_valid_reg;
    logic   st_cmd_reg;
    logic   st_inside_reg;
    idx_t   st_idx_reg;
    value_t st_addend_reg;
    value_t rd_data_reg;
    logic   fwd_hit_reg;
    value_t fwd_data_reg;

    logic   m_tvalid_reg;
    value_t m_tdata_reg;

    value_t in_value;
    oct_t   in_oct;
    coord_t in_x;
    coord_t in_y;
    coord_t in_z;
    logic   in_inside;
    idx_t   in_idx;
    logic   accept;

    logic   out_free;
    logic   st_adv;
    logic   st_we;
    value_t operand;
    logic signed [VALUE_W:0] sum_wide;
    value_t sat_sum;
    value_t st_wdata;

    logic   mem_we;
    idx_t   mem_waddr;
    value_t mem_wdata;

    assign in_value  = value_t'(s_tdata[VALUE_W-1:0]);
    assign in_oct    = s_tdata[VALUE_W +: OCT_W];
    assign in_x      = s_tdata[VALUE_W + OCT_W +: COORD_W];
    assign in_y      = s_tdata[VALUE_W + OCT_W + COORD_W +: COORD_W];
    assign in_z      = s_tdata[VALUE_W + OCT_W + 2*COORD_W +: COORD_W];
    assign in_inside = in_patch(in_x, in_y, in_z);
    assign in_idx    = (s_tuser == CMD_READ) ? cell_index(int'(in_x), int'(in_y), int'(in_z))
                                             : coarse_index(in_oct, in_x, in_y, in_z);

    assign out_free = !m_tvalid_reg || m_tready;
    assign st_adv   = st_valid_reg && ((st_cmd_reg == CMD_ACCUM) || out_free);
    assign s_tready = !clearing_reg && (!st_valid_reg || st_adv);
    assign accept   = s_tvalid && s_tready;

    assign operand  = fwd_hit_reg ? fwd_data_reg : rd_data_reg;
    assign sum_wide = {operand[VALUE_W-1], operand} + {st_addend_reg[VALUE_W-1], st_addend_reg};

    always_comb begin
        if (sum_wide[VALUE_W] != sum_wide[VALUE_W-1]) begin
            sat_sum = sum_wide[VALUE_W] ? {1'b1, {(VALUE_W-1){1'b0}}}
                                        : {1'b0, {(VALUE_W-1){1'b1}}};
        end else begin
            sat_sum = sum_wide[VALUE_W-1:0];
        end
    end

    assign st_wdata = (st_cmd_reg == CMD_READ) ? '0 : sat_sum;
    assign st_we    = st_adv && st_inside_reg;

    always_comb begin
        if (clearing_reg) begin
            mem_we    = 1'b1;
            mem_waddr = clear_cnt_reg;
            mem_wdata = '0;
        end else begin
            mem_we    = st_we;
            mem_waddr = st_idx_reg;
            mem_wdata = st_wdata;
        end
    end

    // Coarse store: one write, one registered read (old data on a same-cell collision)
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (accept) begin
            rd_data_reg <= mem[in_idx];
        end
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clearing_reg  <= 1'b1;
            clear_cnt_reg <= '0;
            st_valid_reg  <= 1'b0;
            m_tvalid_reg  <= 1'b0;
        end else begin
            if (clearing_reg) begin
                clear_cnt_reg <= clear_cnt_reg + 1'b1;
                if (clear_cnt_reg == idx_t'(STORE_DEPTH - 1)) begin
                    clearing_reg <= 1'b0;
                end
            end
            if (accept) begin
                st_valid_reg <= 1'b1;
            end else if (st_adv) begin
                st_valid_reg <= 1'b0;
            end
            if (st_adv && (st_cmd_reg == CMD_READ)) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // Payload
    always_ff @(posedge aclk) begin
        if (accept) begin
            st_cmd_reg    <= s_tuser;
            st_inside_reg <= in_inside;
            st_idx_reg    <= in_idx;
            st_addend_reg <= in_value >>> 3;
            // memory read misses the write landing at this edge
            fwd_hit_reg   <= st_we && (st_idx_reg == in_idx);
            fwd_data_reg  <= st_wdata;
        end
        if (st_adv && (st_cmd_reg == CMD_READ)) begin
            m_tdata_reg <= st_inside_reg ? operand : '0;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = M_TDATA_W'(m_tdata_reg);

endmodule

`default_nettype wire

// ===== src/omgr_checker.sv =====
// Port-level assertions for the restriction block and their bind to the top level.
`default_nettype none

module omgr_checker (
    input wire logic                            aclk,
    input wire logic                            aresetn,
    input wire logic                            s_tvalid,
    input wire logic                            s_tready,
    input wire logic                            s_tuser,
    input wire logic                            m_tvalid,
    input wire logic                            m_tready,
    input wire logic [omgr_pkg::M_TDATA_W-1:0]  m_tdata
);
    import omgr_pkg::*;

    // stalled result holds
    a_m_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("m side result changed while stalled");

    // clearing pass keeps the input closed right after reset
    a_clear_closed: assert property (@(posedge aclk)
        !aresetn |=> !s_tready)
        else $error("input accepted during store clear");

    a_reset_out: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // a new result must trace back to an accepted read transaction
    a_read_to_out: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(s_tvalid && s_tready && (s_tuser == CMD_READ), 2))
        else $error("result without a read transaction");

endmodule

bind octree_multigrid_restriction_top omgr_checker u_omgr_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire
